@@ sv/assert_macros.svh @@
// Assertion helpers used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication written out by the caller (|-> or |=>).
`define ARS_ASSERT(label, ck, rst_n, prop) \
	label: assert property (@(posedge ck) disable iff (!rst_n) prop) \
		else $error("ars check failed");

// Consequence in the cycle after the antecedent.
`define ARS_ASSERT_NEXT(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ars check failed");

`endif

@@ sv/ars_pkg.sv @@
package ars_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int ID_W         = 27;
	localparam int GRADE_W      = 7;
	localparam int SUM_W        = 9;
	localparam int AVG_W        = 11;
	localparam int RANK_W       = 6;

	// ceil(2^16 / 3): exact floor(x / 3) for x below 2^15
	localparam logic [14:0] AVG_RECIP = 15'd21846;

	typedef struct packed {
		logic [ID_W-1:0]    student_id;
		logic [GRADE_W-1:0] grade_one;
		logic [GRADE_W-1:0] grade_two;
		logic [GRADE_W-1:0] grade_three;
		logic               is_last;
	} rec_t;

	typedef struct packed {
		logic [RANK_W-1:0] rank_position;
		logic [AVG_W-1:0]  average_value;
		logic [ID_W-1:0]   best_id;
		logic [AVG_W-1:0]  best_average;
		logic [ID_W-1:0]   worst_id;
		logic [AVG_W-1:0]  worst_average;
		logic              overflowed;
		logic              last_result;
	} res_t;

	typedef struct packed {
		logic             acc;
		logic             clr;
		logic [ID_W-1:0]  id;
		logic [SUM_W-1:0] sum;
	} trk_ctl_t;

	typedef struct packed {
		logic [SUM_W-1:0] best_sum;
		logic [ID_W-1:0]  best_id;
		logic [SUM_W-1:0] worst_sum;
		logic [ID_W-1:0]  worst_id;
		logic             overflow;
		logic             full;
	} trk_st_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PASS_RD,
		ST_PASS_LD,
		ST_SCAN,
		ST_PASS_WR,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_HOLD
	} state_t;

	// floor(sum * 16 / 3) by reciprocal multiply
	function automatic logic [AVG_W-1:0] to_avg(input logic [SUM_W-1:0] s);
		logic [27:0] p;
		p = 28'({s, 4'b0000}) * 28'(AVG_RECIP);
		return p[26:16];
	endfunction

endpackage

@@ sv/record_average_rank_sorter_unit.sv @@
// Load: one record word per cycle; best/worst update and the sum is stored unless full.
// Sort: after the last word, pass i runs over the stored sums from position i on,
//   bound by the single store read port and one compare unit.
// Emit: ST_OUT_RD primes the read; each result word is loaded, then held until taken.
// Reset: arst_n clears the sequencer, output valid and the run tallies at once; the sum
//   store is not cleared and only entries written in the current run are read.
module record_average_rank_sorter_unit #(
	parameter int CAPACITY = ars_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rec_valid,
	output logic          rec_stall,
	input  ars_pkg::rec_t rec_word,
	output logic          res_valid,
	input  logic          res_stall,
	output ars_pkg::res_t res_word
);
	import ars_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	state_t           state_q, state_d;
	logic [AW-1:0]    i_q, j_q, k_q;
	logic [SUM_W-1:0] cur_q;
	res_t             res_q;
	logic             valid_q;

	logic             rec_acc;
	logic [SUM_W-1:0] rec_sum;
	trk_ctl_t         trk_ctl;
	trk_st_t          trk_st;
	logic [CW-1:0]    count;

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [SUM_W-1:0] wr_data;
	logic [AW-1:0]    rd_addr;
	logic [SUM_W-1:0] rd_data;

	logic             swap;
	logic             i_end;
	logic             j_last;
	logic             k_last;
	logic             res_acc;

	assign rec_acc = rec_valid && (state_q == ST_LOAD);
	assign res_acc = valid_q && !res_stall;
	assign rec_sum = SUM_W'(rec_word.grade_one) + SUM_W'(rec_word.grade_two)
		+ SUM_W'(rec_word.grade_three);

	// The one compare unit: held candidate against the entry just read.
	assign swap   = cur_q < rd_data;
	assign i_end  = (CW'(i_q) + CW'(1)) >= count;
	assign j_last = (CW'(j_q) + CW'(1)) == count;
	assign k_last = (CW'(k_q) + CW'(1)) == count;

	ars_store #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ars_track #(
		.CAPACITY (CAPACITY),
		.CW       (CW)
	) u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (trk_ctl),
		.st     (trk_st),
		.count  (count)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (rec_acc && rec_word.is_last) begin
					state_d = ST_PASS_RD;
				end
			end
			ST_PASS_RD: begin
				// a pass with nothing after position i means the order is final
				state_d = i_end ? ST_OUT_RD : ST_PASS_LD;
			end
			ST_PASS_LD: state_d = ST_SCAN;
			ST_SCAN: begin
				if (j_last) begin
					state_d = ST_PASS_WR;
				end
			end
			ST_PASS_WR:  state_d = ST_PASS_RD;
			ST_OUT_RD:   state_d = ST_OUT_LD;
			ST_OUT_LD:   state_d = ST_OUT_HOLD;
			ST_OUT_HOLD: begin
				if (res_acc) begin
					state_d = k_last ? ST_LOAD : ST_OUT_LD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// Store port, tracker and handshake controls.
	always_comb begin
		rd_addr   = i_q;
		wr_en     = 1'b0;
		wr_addr   = j_q;
		wr_data   = cur_q;
		rec_stall = (state_q != ST_LOAD);
		trk_ctl.acc = rec_acc;
		trk_ctl.clr = 1'b0;
		trk_ctl.id  = rec_word.student_id;
		trk_ctl.sum = rec_sum;
		case (state_q)
			ST_LOAD: begin
				// drop the sum from the store once it is full
				wr_en   = rec_acc && !trk_st.full;
				wr_addr = count[AW-1:0];
				wr_data = rec_sum;
			end
			ST_PASS_RD: rd_addr = i_q;
			ST_PASS_LD: rd_addr = i_q + AW'(1);
			ST_SCAN: begin
				// push the held value down, pick up the larger one
				rd_addr = j_q + AW'(1);
				wr_en   = swap;
				wr_addr = j_q;
				wr_data = cur_q;
			end
			ST_PASS_WR: begin
				wr_en   = 1'b1;
				wr_addr = i_q;
				wr_data = cur_q;
			end
			ST_OUT_RD:   rd_addr = k_q;
			ST_OUT_LD:   rd_addr = k_q;
			ST_OUT_HOLD: begin
				rd_addr     = k_q + AW'(1);
				trk_ctl.clr = res_acc && k_last;
			end
			default: rd_addr = i_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			valid_q <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: begin
					if (rec_acc && rec_word.is_last) begin
						i_q <= '0;
					end
				end
				ST_PASS_RD: begin
					if (i_end) begin
						k_q <= '0;
					end
				end
				ST_PASS_LD: j_q <= i_q + AW'(1);
				ST_SCAN:    j_q <= j_q + AW'(1);
				ST_PASS_WR: i_q <= i_q + AW'(1);
				ST_OUT_LD:  valid_q <= 1'b1;
				ST_OUT_HOLD: begin
					if (res_acc) begin
						valid_q <= 1'b0;
						k_q     <= k_q + AW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Held candidate and result word; no reset needed.
	always_ff @(posedge clk) begin
		if (state_q == ST_PASS_LD || (state_q == ST_SCAN && swap)) begin
			cur_q <= rd_data;
		end
		if (state_q == ST_OUT_LD) begin
			res_q.rank_position <= RANK_W'(k_q);
			res_q.average_value <= to_avg(rd_data);
			res_q.best_id       <= trk_st.best_id;
			res_q.best_average  <= to_avg(trk_st.best_sum);
			res_q.worst_id      <= trk_st.worst_id;
			res_q.worst_average <= to_avg(trk_st.worst_sum);
			res_q.overflowed    <= trk_st.overflow;
			res_q.last_result   <= k_last;
		end
	end

	assign res_valid = valid_q;
	assign res_word  = res_q;

endmodule

@@ sv/ars_store.sv @@
module ars_store #(
	parameter int DEPTH = ars_pkg::CAPACITY_DEF,
	parameter int AW    = 6
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [ars_pkg::SUM_W-1:0] wr_data,
	input  logic [AW-1:0]             rd_addr,
	output logic [ars_pkg::SUM_W-1:0] rd_data
);
	import ars_pkg::*;

	logic [SUM_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ sv/ars_track.sv @@
module ars_track #(
	parameter int CAPACITY = ars_pkg::CAPACITY_DEF,
	parameter int CW       = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ars_pkg::trk_ctl_t ctl,
	output ars_pkg::trk_st_t  st,
	output logic [CW-1:0]     count
);
	import ars_pkg::*;

	logic [CW-1:0]    count_q;
	logic             seen_q;
	logic             ovf_q;
	logic [SUM_W-1:0] best_sum_q;
	logic [ID_W-1:0]  best_id_q;
	logic [SUM_W-1:0] worst_sum_q;
	logic [ID_W-1:0]  worst_id_q;
	logic             full;

	assign full = (count_q == CW'(CAPACITY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			seen_q      <= 1'b0;
			ovf_q       <= 1'b0;
			best_sum_q  <= '0;
			best_id_q   <= '0;
			worst_sum_q <= '0;
			worst_id_q  <= '0;
		end else if (ctl.clr) begin
			count_q     <= '0;
			seen_q      <= 1'b0;
			ovf_q       <= 1'b0;
			best_sum_q  <= '0;
			best_id_q   <= '0;
			worst_sum_q <= '0;
			worst_id_q  <= '0;
		end else if (ctl.acc) begin
			seen_q <= 1'b1;
			// strict compares keep the earliest record on a tie
			if (!seen_q || ctl.sum > best_sum_q) begin
				best_sum_q <= ctl.sum;
				best_id_q  <= ctl.id;
			end
			if (!seen_q || ctl.sum < worst_sum_q) begin
				worst_sum_q <= ctl.sum;
				worst_id_q  <= ctl.id;
			end
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	assign count       = count_q;
	assign st.best_sum  = best_sum_q;
	assign st.best_id   = best_id_q;
	assign st.worst_sum = worst_sum_q;
	assign st.worst_id  = worst_id_q;
	assign st.overflow  = ovf_q;
	assign st.full      = full;

endmodule

@@ sv/ars_chk.sv @@
`include "assert_macros.svh"

module ars_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          rec_valid,
	input logic          rec_stall,
	input ars_pkg::rec_t rec_word,
	input logic          res_valid,
	input logic          res_stall,
	input ars_pkg::res_t res_word
);
	import ars_pkg::*;

	// no record is taken while a result word is pending
	`ARS_ASSERT(a_no_load_while_emit, clk, arst_n, res_valid |-> rec_stall)
	// the final record closes the load phase at once
	`ARS_ASSERT_NEXT(a_last_starts_sort, clk, arst_n, rec_valid && !rec_stall && rec_word.is_last, rec_stall && !res_valid)
	// taking the final result reopens the input
	`ARS_ASSERT_NEXT(a_last_reopens, clk, arst_n, res_valid && !res_stall && res_word.last_result, !rec_stall && !res_valid)
	// every stored average lies between worst and best
	`ARS_ASSERT(a_avg_bounds, clk, arst_n, res_valid |-> (res_word.best_average >= res_word.average_value && res_word.average_value >= res_word.worst_average))
	// a stalled result word holds
	`ARS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res_word))

endmodule

bind record_average_rank_sorter_unit ars_chk u_ars_chk (.*);
